### hw/rtl/fsand_pkg.sv
// fsand_pkg: types, codes and reset constants for the falling sand cell step block
// used by fsand_ctrl, fsand_dp and falling_sand_cell_step; no dependencies
package fsand_pkg;

  localparam int GridColsDef = 128;
  localparam int GridRowsDef = 128;

  localparam logic [6:0] FLOW_RATE_RST     = 7'd35;
  localparam logic [7:0] ACTIVE_WIDTH_RST  = 8'd128;
  localparam logic [7:0] ACTIVE_HEIGHT_RST = 8'd128;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_FLOW_RATE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_HEIGHT = 2'd2;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_STEP  = 2'd2;

  localparam logic [1:0] MOVED_NONE  = 2'd0;
  localparam logic [1:0] MOVED_DOWN  = 2'd1;
  localparam logic [1:0] MOVED_LEFT  = 2'd2;
  localparam logic [1:0] MOVED_RIGHT = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [6:0]  col;
    logic [6:0]  row;
    logic [10:0] hue_in;
    logic        right_first;
    logic [6:0]  chance;
  } item_t;

  typedef struct packed {
    logic [10:0] hue_out;
    logic [1:0]  moved;
  } result_t;

  typedef enum logic [1:0] {
    ASEL_CTR,
    ASEL_DN,
    ASEL_D1,
    ASEL_D2
  } addr_sel_e;

  typedef enum logic [1:0] {
    WSEL_HUE,
    WSEL_GRAIN,
    WSEL_ZERO
  } wdata_sel_e;

  typedef struct packed {
    logic       clr_wr;
    logic       item_ld;
    logic       before_ld;
    logic       mem_rd;
    logic       mem_wr;
    addr_sel_e  addr_sel;
    wdata_sel_e wdata_sel;
    logic       moved_ld;
    logic [1:0] moved_val;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic ctr_ok;
    logic op_write;
    logic op_step;
    logic ctr_full;
    logic dn_ok;
    logic dn_free;
    logic d1_free;
    logic d2_free;
    logic slide_ok;
    logic right_first;
  } sts_t;

endpackage

### hw/rtl/fsand_ctrl.sv
// fsand_ctrl: sequencer for clearing, cell reads, hue writes and the grain move writes
// depends on fsand_pkg; drives fsand_dp through cmd_t and watches sts_t
module fsand_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  output logic             result_valid_o,
  input  fsand_pkg::sts_t  sts_i,
  output fsand_pkg::cmd_t  cmd_o
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_CTR   = 4'd2;
  localparam logic [3:0] S_DN    = 4'd3;
  localparam logic [3:0] S_D1    = 4'd4;
  localparam logic [3:0] S_D2    = 4'd5;
  localparam logic [3:0] S_D3    = 4'd6;
  localparam logic [3:0] S_SRC   = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0] state_d, state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.addr_sel = fsand_pkg::ASEL_CTR;
    cmd_o.wdata_sel = fsand_pkg::WSEL_ZERO;
    result_valid_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.item_ld = 1'b1;
          state_d       = S_CTR;
        end
      end
      S_CTR: begin
        cmd_o.mem_rd = sts_i.ctr_ok;
        state_d      = S_DN;
      end
      S_DN: begin
        cmd_o.before_ld = 1'b1;
        state_d         = S_OUT;
        if (sts_i.ctr_ok && sts_i.op_write) begin
          cmd_o.mem_wr    = 1'b1;
          cmd_o.wdata_sel = fsand_pkg::WSEL_HUE;
        end else if (sts_i.ctr_ok && sts_i.op_step && sts_i.ctr_full) begin
          cmd_o.mem_rd   = sts_i.dn_ok;
          cmd_o.addr_sel = fsand_pkg::ASEL_DN;
          state_d        = S_D1;
        end
      end
      S_D1: begin
        state_d = S_OUT;
        if (sts_i.dn_free) begin
          cmd_o.mem_wr    = 1'b1;
          cmd_o.addr_sel  = fsand_pkg::ASEL_DN;
          cmd_o.wdata_sel = fsand_pkg::WSEL_GRAIN;
          cmd_o.moved_ld  = 1'b1;
          cmd_o.moved_val = fsand_pkg::MOVED_DOWN;
          state_d         = S_SRC;
        end else if (sts_i.slide_ok && sts_i.dn_ok) begin
          cmd_o.mem_rd   = 1'b1;
          cmd_o.addr_sel = fsand_pkg::ASEL_D1;
          state_d        = S_D2;
        end
      end
      S_D2: begin
        if (sts_i.d1_free) begin
          cmd_o.mem_wr    = 1'b1;
          cmd_o.addr_sel  = fsand_pkg::ASEL_D1;
          cmd_o.wdata_sel = fsand_pkg::WSEL_GRAIN;
          cmd_o.moved_ld  = 1'b1;
          cmd_o.moved_val = sts_i.right_first ? fsand_pkg::MOVED_RIGHT
                                              : fsand_pkg::MOVED_LEFT;
          state_d         = S_SRC;
        end else begin
          cmd_o.mem_rd   = 1'b1;
          cmd_o.addr_sel = fsand_pkg::ASEL_D2;
          state_d        = S_D3;
        end
      end
      S_D3: begin
        state_d = S_OUT;
        if (sts_i.d2_free) begin
          cmd_o.mem_wr    = 1'b1;
          cmd_o.addr_sel  = fsand_pkg::ASEL_D2;
          cmd_o.wdata_sel = fsand_pkg::WSEL_GRAIN;
          cmd_o.moved_ld  = 1'b1;
          cmd_o.moved_val = sts_i.right_first ? fsand_pkg::MOVED_LEFT
                                              : fsand_pkg::MOVED_RIGHT;
          state_d         = S_SRC;
        end
      end
      S_SRC: begin
        // source cell becomes empty
        cmd_o.mem_wr    = 1'b1;
        cmd_o.addr_sel  = fsand_pkg::ASEL_CTR;
        cmd_o.wdata_sel = fsand_pkg::WSEL_ZERO;
        state_d         = S_OUT;
      end
      S_OUT: begin
        result_valid_o = 1'b1;
        state_d        = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy = (state_q != S_IDLE);

endmodule

### hw/rtl/fsand_dp.sv
// fsand_dp: cell store, configuration registers, address and neighbor checks
// depends on fsand_pkg; commanded by fsand_ctrl
module fsand_dp #(
  parameter int GRID_COLS = fsand_pkg::GridColsDef,
  parameter int GRID_ROWS = fsand_pkg::GridRowsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  fsand_pkg::item_t                    item_i,
  input  logic                                cfg_we_i,
  input  logic [fsand_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [fsand_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  fsand_pkg::cmd_t                     cmd_i,
  output fsand_pkg::sts_t                     sts_o,
  output fsand_pkg::result_t                  result_o
);

  localparam int Depth = GRID_COLS * GRID_ROWS;
  localparam int AddrW = $clog2(Depth);
  localparam int ColW  = $clog2(GRID_COLS + 1);
  localparam int RowW  = $clog2(GRID_ROWS + 1);

  logic [10:0]      cells_q [Depth];
  logic [10:0]      rdata_q;
  logic [AddrW-1:0] clr_cnt_q;
  fsand_pkg::item_t item_q;
  logic [10:0]      before_q;
  logic [1:0]       moved_q;
  logic [6:0]       flow_q;
  logic [7:0]       width_q;
  logic [7:0]       height_q;

  logic [ColW-1:0]  eff_cols;
  logic [RowW-1:0]  eff_rows;
  logic [7:0]       col_c, col_p, col_m, row_c, row_p, col_d1, col_d2;
  logic             r_ok, l_ok, d1_ok, d2_ok, rd_zero;
  logic [AddrW-1:0] mem_addr;
  logic [10:0]      mem_wdata;
  logic             mem_we;

  function automatic logic [AddrW-1:0] cell_addr(input logic [7:0] c, input logic [7:0] r);
    cell_addr = AddrW'(int'(r) * GRID_COLS + int'(c));
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flow_q   <= fsand_pkg::FLOW_RATE_RST;
      width_q  <= fsand_pkg::ACTIVE_WIDTH_RST;
      height_q <= fsand_pkg::ACTIVE_HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fsand_pkg::CFG_FLOW_RATE:     flow_q   <= cfg_data_i[6:0];
        fsand_pkg::CFG_ACTIVE_WIDTH:  width_q  <= cfg_data_i;
        fsand_pkg::CFG_ACTIVE_HEIGHT: height_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // active size saturated to the grid, a zero size taken as one
  always_comb begin
    if (width_q == 8'd0) begin
      eff_cols = ColW'(1);
    end else if (int'(width_q) > GRID_COLS) begin
      eff_cols = ColW'(GRID_COLS);
    end else begin
      eff_cols = ColW'(width_q);
    end
    if (height_q == 8'd0) begin
      eff_rows = RowW'(1);
    end else if (int'(height_q) > GRID_ROWS) begin
      eff_rows = RowW'(GRID_ROWS);
    end else begin
      eff_rows = RowW'(height_q);
    end
  end

  assign col_c  = {1'b0, item_q.col};
  assign col_p  = col_c + 8'd1;
  assign col_m  = col_c - 8'd1;
  assign row_c  = {1'b0, item_q.row};
  assign row_p  = row_c + 8'd1;
  assign r_ok   = int'(col_p) < int'(eff_cols);
  assign l_ok   = (item_q.col != 7'd0);
  assign col_d1 = item_q.right_first ? col_p : col_m;
  assign col_d2 = item_q.right_first ? col_m : col_p;
  assign d1_ok  = item_q.right_first ? r_ok : l_ok;
  assign d2_ok  = item_q.right_first ? l_ok : r_ok;
  assign rd_zero = (rdata_q == 11'd0);

  always_comb begin
    sts_o.clr_last    = (clr_cnt_q == AddrW'(Depth - 1));
    sts_o.ctr_ok      = (int'(col_c) < int'(eff_cols)) && (int'(row_c) < int'(eff_rows));
    sts_o.op_write    = (item_q.op == fsand_pkg::OP_WRITE);
    sts_o.op_step     = (item_q.op == fsand_pkg::OP_STEP);
    sts_o.ctr_full    = !rd_zero;
    sts_o.dn_ok       = int'(row_p) < int'(eff_rows);
    sts_o.dn_free     = sts_o.dn_ok && rd_zero;
    sts_o.d1_free     = sts_o.dn_ok && d1_ok && rd_zero;
    sts_o.d2_free     = sts_o.dn_ok && d2_ok && rd_zero;
    sts_o.slide_ok    = item_q.chance < flow_q;
    sts_o.right_first = item_q.right_first;
  end

  always_comb begin
    case (cmd_i.addr_sel)
      fsand_pkg::ASEL_CTR: mem_addr = cell_addr(col_c, row_c);
      fsand_pkg::ASEL_DN:  mem_addr = cell_addr(col_c, row_p);
      fsand_pkg::ASEL_D1:  mem_addr = cell_addr(col_d1, row_p);
      fsand_pkg::ASEL_D2:  mem_addr = cell_addr(col_d2, row_p);
      default:             mem_addr = cell_addr(col_c, row_c);
    endcase
    if (cmd_i.clr_wr) begin
      mem_addr = clr_cnt_q;
    end
    case (cmd_i.wdata_sel)
      fsand_pkg::WSEL_HUE:   mem_wdata = item_q.hue_in;
      fsand_pkg::WSEL_GRAIN: mem_wdata = before_q;
      default:               mem_wdata = 11'd0;
    endcase
    if (cmd_i.clr_wr) begin
      mem_wdata = 11'd0;
    end
  end

  assign mem_we = cmd_i.mem_wr || cmd_i.clr_wr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cells_q[mem_addr] <= mem_wdata;
    end
    if (cmd_i.mem_rd) begin
      rdata_q <= cells_q[mem_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_cnt_q <= clr_cnt_q + AddrW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.item_ld) begin
      item_q  <= item_i;
      moved_q <= fsand_pkg::MOVED_NONE;
    end else if (cmd_i.moved_ld) begin
      moved_q <= cmd_i.moved_val;
    end
    if (cmd_i.before_ld) begin
      before_q <= sts_o.ctr_ok ? rdata_q : 11'd0;
    end
  end

  assign result_o.hue_out = before_q;
  assign result_o.moved   = moved_q;

endmodule

### hw/rtl/falling_sand_cell_step.sv
// Falling sand grid, one cell operation per command. After reset the block
// zeroes the whole store, one cell a cycle, with busy high; configuration
// writes are taken during that pass. The single store port serialises the
// work, and start is taken only while busy is low: a write or read does the
// center read first, a step the center read, below read, up to two diagonal
// reads, destination and source writes. The result is on result_o for one
// cycle with result_valid_o high and cannot be held off by the receiver.
module falling_sand_cell_step #(
  parameter int GRID_COLS = fsand_pkg::GridColsDef,
  parameter int GRID_ROWS = fsand_pkg::GridRowsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  fsand_pkg::item_t                 item_i,
  output logic                             result_valid_o,
  output fsand_pkg::result_t               result_o,
  input  logic                             cfg_we_i,
  input  logic [fsand_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fsand_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  fsand_pkg::cmd_t cmd;
  fsand_pkg::sts_t sts;

  fsand_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .result_valid_o (result_valid_o),
    .sts_i          (sts),
    .cmd_o          (cmd)
  );

  fsand_dp #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .result_o   (result_o)
  );

`ifndef NO_ASSERTIONS
  a_strobe_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy) else $error("result strobe outside a transfer");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("result strobe held");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted command not started");

  a_move_has_grain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (result_o.moved != fsand_pkg::MOVED_NONE))
      |-> (result_o.hue_out != 11'd0)) else $error("move of an empty cell");
`endif

endmodule

### tb/tb_top.sv
// tb_top: self-checking testbench for falling_sand_cell_step, directed and random cell ops
// depends on fsand_pkg and falling_sand_cell_step; predicts every result from its own grid copy
`timescale 1ns / 100ps

module tb_top;

  localparam int GRID_COLS = fsand_pkg::GridColsDef;
  localparam int GRID_ROWS = fsand_pkg::GridRowsDef;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic                             clk_i;
  logic                             rst_ni;
  logic                             start;
  logic                             busy;
  fsand_pkg::item_t                 cmd_item;
  logic                             result_valid_o;
  fsand_pkg::result_t               result_o;
  logic                             cfg_we_i;
  logic [fsand_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [fsand_pkg::CFG_DATA_W-1:0] cfg_data_i;

  logic [10:0]        sand_model [GRID_COLS*GRID_ROWS];
  logic [6:0]         pred_flow;
  logic [7:0]         pred_width;
  logic [7:0]         pred_height;
  fsand_pkg::result_t cell_results_due [$];
  int                 fail_count;
  int                 idle_pct;

  falling_sand_cell_step dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (cmd_item),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic int clamp_size(logic [7:0] v, int lim);
    if (v == 8'd0) return 1;
    if (int'(v) > lim) return lim;
    return int'(v);
  endfunction

  function automatic bit cell_free(int c, int r);
    if (c < 0 || r < 0) return 1'b0;
    if (c >= clamp_size(pred_width, GRID_COLS) || r >= clamp_size(pred_height, GRID_ROWS)) begin
      return 1'b0;
    end
    return sand_model[r*GRID_COLS + c] == 11'd0;
  endfunction

  function automatic fsand_pkg::result_t next_cell_result(fsand_pkg::item_t it);
    fsand_pkg::result_t res;
    int c;
    int r;
    int dir;
    res = '0;
    c = int'(it.col);
    r = int'(it.row);
    dir = 0;
    if (c < clamp_size(pred_width, GRID_COLS) && r < clamp_size(pred_height, GRID_ROWS)) begin
      res.hue_out = sand_model[r*GRID_COLS + c];
      if (it.op == fsand_pkg::OP_WRITE) begin
        sand_model[r*GRID_COLS + c] = it.hue_in;
      end else if (it.op == fsand_pkg::OP_STEP && res.hue_out != 11'd0) begin
        if (cell_free(c, r + 1)) begin
          res.moved = fsand_pkg::MOVED_DOWN;
        end else if (it.chance < pred_flow) begin
          dir = it.right_first ? 1 : -1;
          if (!cell_free(c + dir, r + 1)) dir = -dir;
          if (!cell_free(c + dir, r + 1)) dir = 0;
          if (dir > 0) res.moved = fsand_pkg::MOVED_RIGHT;
          else if (dir < 0) res.moved = fsand_pkg::MOVED_LEFT;
        end
        if (res.moved != fsand_pkg::MOVED_NONE) begin
          sand_model[(r + 1)*GRID_COLS + c + dir] = res.hue_out;
          sand_model[r*GRID_COLS + c] = 11'd0;
        end
      end
    end
    return res;
  endfunction

  function automatic fsand_pkg::item_t cell_cmd(logic [1:0] op, int c, int r, int hue, int rf,
                                                int ch);
    fsand_pkg::item_t it;
    it.op = op;
    it.col = 7'(c);
    it.row = 7'(r);
    it.hue_in = 11'(hue);
    it.right_first = 1'(rf);
    it.chance = 7'(ch);
    return it;
  endfunction

  // entered and left at a falling edge; start stays high for a back-to-back transfer
  task automatic issue_cell_op(input fsand_pkg::item_t it);
    fsand_pkg::result_t due;
    while ($urandom_range(0, 99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    start = 1'b1;
    cmd_item = it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    due = next_cell_result(it);
    cell_results_due = {cell_results_due, due};
    @(negedge clk_i);
  endtask

  task automatic set_reg(input logic [fsand_pkg::CFG_IDX_W-1:0] idx,
                         input logic [fsand_pkg::CFG_DATA_W-1:0] val);
    start = 1'b0;
    while (cell_results_due.size() != 0) @(negedge clk_i);
    while (busy) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      fsand_pkg::CFG_FLOW_RATE:     pred_flow = val[6:0];
      fsand_pkg::CFG_ACTIVE_WIDTH:  pred_width = val;
      fsand_pkg::CFG_ACTIVE_HEIGHT: pred_height = val;
      default: ;
    endcase
  endtask

  task automatic test_directed();
    idle_pct = 0;
    issue_cell_op(cell_cmd(fsand_pkg::OP_READ, 0, 0, 0, 0, 0));
    issue_cell_op(cell_cmd(fsand_pkg::OP_WRITE, 5, 5, 1440, 0, 0));
    issue_cell_op(cell_cmd(fsand_pkg::OP_STEP, 5, 5, 0, 0, 99));
    issue_cell_op(cell_cmd(OP_UNUSED, 5, 6, 0, 0, 0));
    issue_cell_op(cell_cmd(fsand_pkg::OP_STEP, 5, 5, 0, 1, 0));
    // bottom row grain never moves
    issue_cell_op(cell_cmd(fsand_pkg::OP_WRITE, 127, 127, 2047, 0, 0));
    issue_cell_op(cell_cmd(fsand_pkg::OP_STEP, 127, 127, 0, 1, 0));
    issue_cell_op(cell_cmd(fsand_pkg::OP_WRITE, 10, 11, 4, 0, 0));
    issue_cell_op(cell_cmd(fsand_pkg::OP_WRITE, 10, 10, 8, 0, 0));
    issue_cell_op(cell_cmd(fsand_pkg::OP_STEP, 10, 10, 0, 1, 0));
    issue_cell_op(cell_cmd(fsand_pkg::OP_WRITE, 20, 11, 12, 0, 0));
    issue_cell_op(cell_cmd(fsand_pkg::OP_WRITE, 20, 10, 16, 0, 0));
    issue_cell_op(cell_cmd(fsand_pkg::OP_STEP, 20, 10, 0, 0, 34));
    // left side now blocked: chance at and above flow rate, then a slide to the right
    issue_cell_op(cell_cmd(fsand_pkg::OP_WRITE, 20, 10, 24, 0, 0));
    issue_cell_op(cell_cmd(fsand_pkg::OP_STEP, 20, 10, 0, 0, 35));
    issue_cell_op(cell_cmd(fsand_pkg::OP_STEP, 20, 10, 0, 0, 127));
    issue_cell_op(cell_cmd(fsand_pkg::OP_STEP, 20, 10, 0, 0, 0));
    // side edges count as occupied
    issue_cell_op(cell_cmd(fsand_pkg::OP_WRITE, 0, 21, 28, 0, 0));
    issue_cell_op(cell_cmd(fsand_pkg::OP_WRITE, 0, 20, 32, 0, 0));
    issue_cell_op(cell_cmd(fsand_pkg::OP_STEP, 0, 20, 0, 0, 0));
    issue_cell_op(cell_cmd(fsand_pkg::OP_WRITE, 127, 31, 36, 0, 0));
    issue_cell_op(cell_cmd(fsand_pkg::OP_WRITE, 127, 30, 40, 0, 0));
    issue_cell_op(cell_cmd(fsand_pkg::OP_STEP, 127, 30, 0, 1, 0));
    issue_cell_op(cell_cmd(fsand_pkg::OP_WRITE, 0, 20, 0, 0, 0));
    issue_cell_op(cell_cmd(fsand_pkg::OP_WRITE, 0, 20, 44, 0, 0));
    issue_cell_op(cell_cmd(fsand_pkg::OP_STEP, 0, 20, 0, 0, 0));
  endtask

  task automatic test_grid_limits();
    idle_pct = 0;
    set_reg(fsand_pkg::CFG_ACTIVE_WIDTH, 8'd0);
    set_reg(fsand_pkg::CFG_ACTIVE_HEIGHT, 8'd255);
    issue_cell_op(cell_cmd(fsand_pkg::OP_WRITE, 1, 0, 100, 0, 0));
    issue_cell_op(cell_cmd(fsand_pkg::OP_WRITE, 0, 0, 100, 0, 0));
    issue_cell_op(cell_cmd(fsand_pkg::OP_STEP, 0, 0, 0, 1, 0));
    issue_cell_op(cell_cmd(fsand_pkg::OP_READ, 0, 1, 0, 0, 0));
    set_reg(fsand_pkg::CFG_FLOW_RATE, 8'd100);
    set_reg(fsand_pkg::CFG_ACTIVE_WIDTH, 8'd3);
    set_reg(fsand_pkg::CFG_ACTIVE_HEIGHT, 8'd2);
    issue_cell_op(cell_cmd(fsand_pkg::OP_WRITE, 1, 1, 200, 0, 0));
    issue_cell_op(cell_cmd(fsand_pkg::OP_WRITE, 1, 0, 300, 0, 0));
    issue_cell_op(cell_cmd(fsand_pkg::OP_STEP, 1, 0, 0, 1, 99));
    issue_cell_op(cell_cmd(fsand_pkg::OP_STEP, 0, 1, 0, 1, 0));
    issue_cell_op(cell_cmd(fsand_pkg::OP_WRITE, 2, 0, 50, 0, 0));
    issue_cell_op(cell_cmd(fsand_pkg::OP_STEP, 2, 0, 0, 1, 0));
    set_reg(fsand_pkg::CFG_FLOW_RATE, 8'd127);
    issue_cell_op(cell_cmd(fsand_pkg::OP_WRITE, 1, 1, 0, 0, 0));
    issue_cell_op(cell_cmd(fsand_pkg::OP_STEP, 2, 0, 0, 0, 120));
    set_reg(fsand_pkg::CFG_ACTIVE_HEIGHT, 8'd1);
    issue_cell_op(cell_cmd(fsand_pkg::OP_STEP, 0, 1, 0, 0, 0));
    issue_cell_op(cell_cmd(fsand_pkg::OP_STEP, 1, 0, 0, 0, 0));
    issue_cell_op(cell_cmd(fsand_pkg::OP_WRITE, 100, 100, 5, 0, 0));
    set_reg(fsand_pkg::CFG_FLOW_RATE, 8'd0);
    set_reg(fsand_pkg::CFG_ACTIVE_WIDTH, 8'd128);
    set_reg(fsand_pkg::CFG_ACTIVE_HEIGHT, 8'd128);
  endtask

  // partly filled windows swept bottom up, plus reads, writes and unconstrained noise
  task automatic test_sand_flow(input int n_items, input int idle, input int flow,
                                input int w, input int h);
    int sent;
    int cols;
    int rows;
    int rw;
    int rh;
    int c0;
    int r0;
    int roll;
    int c;
    int r;
    int k;
    bit rtl;
    fsand_pkg::item_t it;
    set_reg(fsand_pkg::CFG_FLOW_RATE, 8'(flow));
    set_reg(fsand_pkg::CFG_ACTIVE_WIDTH, 8'(w));
    set_reg(fsand_pkg::CFG_ACTIVE_HEIGHT, 8'(h));
    idle_pct = idle;
    cols = clamp_size(pred_width, GRID_COLS);
    rows = clamp_size(pred_height, GRID_ROWS);
    sent = 0;
    while (sent < n_items) begin
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
        rw = $urandom_range(1, (cols < 6) ? cols : 6);
        rh = $urandom_range(1, (rows < 6) ? rows : 6);
        c0 = $urandom_range(0, cols - rw);
        r0 = $urandom_range(0, rows - rh);
        for (k = 0; k < rw*rh; k++) begin
          if ($urandom_range(0, 1) == 1) begin
            issue_cell_op(cell_cmd(fsand_pkg::OP_WRITE, c0 + $urandom_range(0, rw - 1),
                                   r0 + $urandom_range(0, rh - 1),
                                   $urandom_range(1, 1440), 0, 0));
            sent++;
          end
        end
        rtl = 1'($urandom_range(0, 1));
        for (r = r0 + rh - 1; r >= r0; r--) begin
          for (k = 0; k < rw; k++) begin
            c = rtl ? c0 + rw - 1 - k : c0 + k;
            issue_cell_op(cell_cmd(fsand_pkg::OP_STEP, c, r, $urandom_range(0, 2047),
                                   $urandom_range(0, 1),
                                   ($urandom_range(0, 9) == 0) ? $urandom_range(100, 127)
                                                               : $urandom_range(0, 99)));
            sent++;
          end
        end
      end else if (roll < 75) begin
        issue_cell_op(cell_cmd(($urandom_range(0, 3) == 0) ? OP_UNUSED : fsand_pkg::OP_READ,
                               $urandom_range(0, cols - 1), $urandom_range(0, rows - 1),
                               $urandom_range(0, 2047), $urandom_range(0, 1),
                               $urandom_range(0, 127)));
        sent++;
      end else if (roll < 85) begin
        issue_cell_op(cell_cmd(fsand_pkg::OP_WRITE, $urandom_range(0, cols - 1),
                               $urandom_range(0, rows - 1),
                               ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2047)
                                                           : $urandom_range(1, 1440),
                               $urandom_range(0, 1), $urandom_range(0, 127)));
        sent++;
      end else begin
        it.op = 2'($urandom_range(0, 3));
        it.col = 7'($urandom_range(0, 127));
        it.row = 7'($urandom_range(0, 127));
        it.hue_in = 11'($urandom_range(0, 2047));
        it.right_first = 1'($urandom_range(0, 1));
        it.chance = 7'($urandom_range(0, 127));
        issue_cell_op(it);
        sent++;
      end
    end
  endtask

  always @(posedge clk_i) begin
    fsand_pkg::result_t want;
    if (rst_ni && result_valid_o) begin
      if (cell_results_due.size() == 0) begin
        $error("unexpected result transfer: hue_out %0d moved %0d",
               result_o.hue_out, result_o.moved);
        fail_count++;
      end else begin
        want = cell_results_due.pop_front();
        if (result_o.hue_out !== want.hue_out) begin
          $error("hue_out mismatch: expected %0d, actual %0d", want.hue_out, result_o.hue_out);
          fail_count++;
        end
        if (result_o.moved !== want.moved) begin
          $error("moved mismatch: expected %0d, actual %0d", want.moved, result_o.moved);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("FAIL falling_sand_cell_step");
    $finish;
  end

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    start = 1'b0;
    cmd_item = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    fail_count = 0;
    idle_pct = 0;
    foreach (sand_model[i]) sand_model[i] = 11'd0;
    pred_flow = fsand_pkg::FLOW_RATE_RST;
    pred_width = fsand_pkg::ACTIVE_WIDTH_RST;
    pred_height = fsand_pkg::ACTIVE_HEIGHT_RST;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_grid_limits();
    test_sand_flow(130, 0, 100, 8, 6);
    test_sand_flow(100, 88, 0, 128, 128);
    test_sand_flow(110, 34, 127, 255, 3);
    test_sand_flow(110, 0, $urandom_range(1, 99), 5, 128);

    start = 1'b0;
    while (cell_results_due.size() != 0) @(negedge clk_i);
    while (busy) @(negedge clk_i);
    repeat (16) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("PASS falling_sand_cell_step");
    end else begin
      $display("FAIL falling_sand_cell_step");
    end
    $finish;
  end

endmodule

### falling_sand_cell_step.f
hw/rtl/fsand_pkg.sv
hw/rtl/fsand_ctrl.sv
hw/rtl/fsand_dp.sv
hw/rtl/falling_sand_cell_step.sv
tb/tb_top.sv
